### design/cdl_pkg.sv
package cdl_pkg;

	typedef logic signed [47:0] q24_t;

	typedef struct packed {
		logic signed [31:0] in_red;
		logic signed [31:0] in_green;
		logic signed [31:0] in_blue;
		logic signed [31:0] in_alpha;
		logic               end_of_run;
	} cdl_in_t;

	typedef struct packed {
		logic signed [31:0] out_red;
		logic signed [31:0] out_green;
		logic signed [31:0] out_blue;
		logic signed [31:0] out_alpha;
		logic               last_out;
	} cdl_out_t;

	typedef struct packed {
		logic        clamp;
		logic [15:0] power;
	} cdl_pow_ctrl_t;

	typedef struct packed {
		logic        bypass;
		logic [15:0] factor;
	} cdl_sat_ctrl_t;

	localparam int unsigned SAT_LAT = 7;
	localparam int unsigned POW_LAT = 55;

	localparam logic [2:0] REG_STYLE      = 3'd0;
	localparam logic [2:0] REG_SLOPE      = 3'd1;
	localparam logic [2:0] REG_OFFSET     = 3'd2;
	localparam logic [2:0] REG_POWER      = 3'd3;
	localparam logic [2:0] REG_SATURATION = 3'd4;
	localparam logic [2:0] REG_IN_SCALE   = 3'd5;
	localparam logic [2:0] REG_OUT_SCALE  = 3'd6;

	localparam int unsigned STYLE_NOCLAMP_BIT = 0;
	localparam int unsigned STYLE_REVERSE_BIT = 1;

	localparam q24_t ONE_Q24 = 48'sd16777216;
	localparam q24_t MAX48   = 48'sh7FFF_FFFF_FFFF;
	localparam q24_t MIN48   = 48'sh8000_0000_0000;
	localparam logic signed [63:0] MAX48_W = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] MIN48_W = 64'shFFFF_8000_0000_0000;

	localparam logic [15:0] LUMA_W [3] = '{16'd13933, 16'd46871, 16'd4732};

	function automatic q24_t sat48(input logic signed [63:0] v);
		if (v > MAX48_W) begin
			return MAX48;
		end
		if (v < MIN48_W) begin
			return MIN48;
		end
		return v[47:0];
	endfunction

	function automatic logic [47:0] mag48(input q24_t v);
		return v[47] ? 48'(-v) : 48'(v);
	endfunction

	// Rounds a product magnitude to nearest, halves away from zero, then restores the sign.
	function automatic q24_t mulq_fin(input logic [63:0] m, input logic neg,
			input logic [4:0] sh);
		logic [63:0]        r;
		logic signed [63:0] s;
		r = (m + (64'd1 << (sh - 5'd1))) >> sh;
		s = neg ? -$signed(r) : $signed(r);
		return sat48(s);
	endfunction

	function automatic q24_t clamp01(input q24_t v);
		if (v < 0) begin
			return '0;
		end
		if (v > ONE_Q24) begin
			return ONE_Q24;
		end
		return v;
	endfunction

	function automatic q24_t add_off(input q24_t v, input logic [15:0] o);
		logic signed [63:0] s;
		s = 64'(v) + (64'($signed(o)) <<< 12);
		return sat48(s);
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bt;
		logic [63:0] rem;
		res = '0;
		bt  = 64'd1 << 62;
		rem = v;
		for (int j = 0; j < 32; j++) begin
			if (bt > rem) begin
				bt = bt >> 2;
			end
		end
		for (int j = 0; j < 32; j++) begin
			if (bt != 0) begin
				if (rem >= res + bt) begin
					rem = rem - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-i) in Q2.30, by i repeated square roots of 2.0.
	function automatic logic [31:0] root_const(input int unsigned i);
		logic [63:0] r;
		r = 64'd1 << 31;
		for (int j = 1; j <= 24; j++) begin
			if (j <= i) begin
				r = isqrt64(r << 30);
			end
		end
		return r[31:0];
	endfunction

endpackage

### design/cdl_sat_pipe.sv
module cdl_sat_pipe (
	input  logic                    clk,
	input  logic                    adv,
	input  cdl_pkg::cdl_sat_ctrl_t  ctrl,
	input  cdl_pkg::q24_t           c_in  [3],
	output cdl_pkg::q24_t           c_out [3]
);

	cdl_pkg::q24_t c_s1 [3];
	cdl_pkg::q24_t c_s2 [3];
	cdl_pkg::q24_t c_s3 [3];
	cdl_pkg::q24_t c_s4 [3];
	cdl_pkg::q24_t c_s5 [3];
	cdl_pkg::q24_t c_s6 [3];
	cdl_pkg::q24_t o_s7 [3];
	logic [63:0]   p_s1 [3];
	logic          n_s1 [3];
	cdl_pkg::q24_t t_s2 [3];
	cdl_pkg::q24_t luma_s3;
	cdl_pkg::q24_t luma_s4;
	cdl_pkg::q24_t luma_s5;
	cdl_pkg::q24_t luma_s6;
	cdl_pkg::q24_t d_s4 [3];
	logic [63:0]   p_s5 [3];
	logic          n_s5 [3];
	cdl_pkg::q24_t f_s6 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				c_s1[ch] <= c_in[ch];
				p_s1[ch] <= cdl_pkg::mag48(c_in[ch]) * cdl_pkg::LUMA_W[ch];
				n_s1[ch] <= c_in[ch][47];
				c_s2[ch] <= c_s1[ch];
				t_s2[ch] <= cdl_pkg::mulq_fin(p_s1[ch], n_s1[ch], 5'd16);
				c_s3[ch] <= c_s2[ch];
				c_s4[ch] <= c_s3[ch];
				d_s4[ch] <= cdl_pkg::sat48(64'(c_s3[ch]) - 64'(luma_s3));
				c_s5[ch] <= c_s4[ch];
				p_s5[ch] <= cdl_pkg::mag48(d_s4[ch]) * ctrl.factor;
				n_s5[ch] <= d_s4[ch][47];
				c_s6[ch] <= c_s5[ch];
				f_s6[ch] <= cdl_pkg::mulq_fin(p_s5[ch], n_s5[ch], 5'd12);
				o_s7[ch] <= ctrl.bypass ? c_s6[ch] :
					cdl_pkg::sat48(64'(luma_s6) + 64'(f_s6[ch]));
			end
			luma_s3 <= cdl_pkg::sat48(64'(t_s2[0]) + 64'(t_s2[1]) + 64'(t_s2[2]));
			luma_s4 <= luma_s3;
			luma_s5 <= luma_s4;
			luma_s6 <= luma_s5;
		end
	end

	assign c_out = o_s7;

endmodule

### design/cdl_pow_pipe.sv
module cdl_pow_pipe (
	input  logic                    clk,
	input  logic                    adv,
	input  cdl_pkg::cdl_pow_ctrl_t  ctrl,
	input  cdl_pkg::q24_t           x_in,
	output cdl_pkg::q24_t           y_out
);

	localparam int unsigned NSTEP = 24;

	typedef struct packed {
		logic          pass;
		logic          zp;
		logic          zx;
		cdl_pkg::q24_t xv;
	} pow_side_t;

	pow_side_t            side_s [cdl_pkg::POW_LAT-1];
	cdl_pkg::q24_t        xc;
	logic [47:0]          ux_s1;
	logic [47:0]          ux_s2;
	logic [5:0]           n_s2;
	logic [5:0]           lead;
	logic [31:0]          m_s3;
	logic [5:0]           n_s3;
	logic [31:0]          sq_m  [NSTEP+1];
	logic [23:0]          sq_lg [NSTEP+1];
	logic [5:0]           sq_n  [NSTEP+1];
	logic signed [30:0]   nb;
	logic signed [30:0]   lg_s28;
	logic [45:0]          yp_s29;
	logic                 yn_s29;
	logic [33:0]          yr;
	logic signed [34:0]   y_s30;
	logic signed [10:0]   ex_k [NSTEP+1];
	logic [23:0]          ex_f [NSTEP+1];
	logic [31:0]          ex_acc [NSTEP+1];
	logic [63:0]          wide;
	logic signed [11:0]   sd;
	logic [63:0]          rnd;
	cdl_pkg::q24_t        pow_res;
	cdl_pkg::q24_t        y_s56;
	pow_side_t            side_last;

	assign xc = ctrl.clamp ? cdl_pkg::clamp01(x_in) : x_in;

	always_comb begin
		lead = '0;
		for (int i = 0; i < 48; i++) begin
			if (ux_s1[i]) begin
				lead = 6'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= '{pass: xc[47], zp: (ctrl.power == '0), zx: (xc == '0), xv: xc};
			ux_s1     <= xc;
			ux_s2     <= ux_s1;
			n_s2      <= lead;
			n_s3      <= n_s2;
			if (n_s2 >= 6'd31) begin
				m_s3 <= 32'(ux_s2 >> (n_s2 - 6'd31));
			end else begin
				m_s3 <= 32'(ux_s2 << (6'd31 - n_s2));
			end
		end
	end

	genvar g;
	generate
		for (g = 1; g < cdl_pkg::POW_LAT - 1; g++) begin : g_side
			always_ff @(posedge clk) begin
				if (adv) begin
					side_s[g] <= side_s[g-1];
				end
			end
		end
	endgenerate

	assign sq_m[0]  = m_s3;
	assign sq_lg[0] = '0;
	assign sq_n[0]  = n_s3;

	// Logarithm: one fraction bit per stage from squaring the mantissa.
	generate
		for (g = 0; g < NSTEP; g++) begin : g_log
			logic [63:0] z;
			assign z = 64'(sq_m[g]) * 64'(sq_m[g]);
			always_ff @(posedge clk) begin
				if (adv) begin
					sq_m[g+1]  <= z[63] ? z[63:32] : z[62:31];
					sq_lg[g+1] <= {sq_lg[g][22:0], z[63]};
					sq_n[g+1]  <= sq_n[g];
				end
			end
		end
	endgenerate

	assign nb = 31'($signed({1'b0, sq_n[NSTEP]})) - 31'sd24;
	assign yr = 34'((64'(yp_s29) + 64'd2048) >> 12);

	always_ff @(posedge clk) begin
		if (adv) begin
			lg_s28 <= $signed({7'b0, sq_lg[NSTEP]}) + (nb <<< 24);
			yp_s29 <= (lg_s28[30] ? 30'(-lg_s28) : 30'(lg_s28)) * ctrl.power;
			yn_s29 <= lg_s28[30];
			y_s30  <= yn_s29 ? -$signed({1'b0, yr}) : $signed({1'b0, yr});
		end
	end

	assign ex_k[0]   = 11'(y_s30 >>> 24);
	assign ex_f[0]   = y_s30[23:0];
	assign ex_acc[0] = 32'd1 << 30;

	// Exponential: one conditional root multiply per stage, index 0 held unregistered.
	generate
		for (g = 1; g <= NSTEP; g++) begin : g_exp
			localparam logic [31:0] ROOT = cdl_pkg::root_const(g);
			logic [63:0] prod;
			assign prod = 64'(ex_acc[g-1]) * 64'(ROOT) + 64'd536870912;
			always_ff @(posedge clk) begin
				if (adv) begin
					ex_acc[g] <= ex_f[g-1][NSTEP-g] ? prod[61:30] : ex_acc[g-1];
					ex_k[g]   <= ex_k[g-1];
					ex_f[g]   <= ex_f[g-1];
				end
			end
		end
	endgenerate

	logic signed [10:0] k_fin;
	assign k_fin     = ex_k[NSTEP];
	assign side_last = side_s[cdl_pkg::POW_LAT-2];

	always_comb begin
		wide    = 64'(ex_acc[NSTEP]) << 5'(k_fin - 11'sd6);
		sd      = 12'sd6 - 12'(k_fin);
		rnd     = (64'(ex_acc[NSTEP]) + (64'd1 << (sd[5:0] - 6'd1))) >> sd[5:0];
		pow_res = '0;
		if (k_fin >= 11'sd6) begin
			if (wide > 64'(cdl_pkg::MAX48)) begin
				pow_res = cdl_pkg::MAX48;
			end else begin
				pow_res = wide[47:0];
			end
		end else if (sd < 12'sd40) begin
			pow_res = rnd[47:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_last.pass) begin
				y_s56 <= side_last.xv;
			end else if (side_last.zp) begin
				y_s56 <= cdl_pkg::ONE_Q24;
			end else if (side_last.zx) begin
				y_s56 <= '0;
			end else if (k_fin >= 11'sd24) begin
				y_s56 <= cdl_pkg::MAX48;
			end else begin
				y_s56 <= pow_res;
			end
		end
	end

	assign y_out = y_s56;

endmodule

### design/cdl_color_grade_core.sv
// Colour decision list grading of one RGBA pixel per clock while the output does not stall. Each
// request is scaled into the unit domain, graded by slope, offset, power and luma saturation in
// forward or reverse order with optional clamping, scaled to the output domain and saturated to
// signed Q16.16; alpha is only scaled. The pipeline takes a new request every cycle unless it is
// stalled; the power unit spends 24 stages of 32 by 32 multiplies on the logarithm and 24 on the
// exponential. A stall on the output while a result waits in the last stage freezes the whole
// pipeline and holds the input stall high. Registers must be written only while no request is in
// flight; the block does not enforce this, the user must. An index above six is ignored.
module cdl_color_grade_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cdl_pkg::cdl_in_t  in_req,
	output logic              out_valid,
	input  logic              out_stall,
	output cdl_pkg::cdl_out_t out_req,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [47:0]       cfg_data
);

	localparam int unsigned MID_LAT = 7 + 2 * cdl_pkg::SAT_LAT + cdl_pkg::POW_LAT;
	localparam int unsigned LAT     = 8 + MID_LAT;

	logic [1:0]  style_q;
	logic [47:0] slope_q;
	logic [47:0] offset_q;
	logic [47:0] power_q;
	logic [15:0] sat_q;
	logic [31:0] in_scale_q;
	logic [39:0] out_scale_q;

	logic adv;
	logic fwd;
	logic rev;
	logic clamp;

	logic [LAT-1:0] vld_s;
	logic [LAT-1:0] lst_s;
	cdl_pkg::q24_t  alpha_s [MID_LAT];

	logic signed [31:0] x_in [4];
	logic [63:0]   isp_s1 [4];
	logic          isn_s1 [4];
	cdl_pkg::q24_t v_s2   [4];
	cdl_pkg::q24_t ca     [3];
	cdl_pkg::q24_t c_s3   [3];
	logic [63:0]   sp_s3  [3];
	logic          sn_s3  [3];
	cdl_pkg::q24_t c_s4   [3];
	cdl_pkg::q24_t c_s5   [3];
	cdl_pkg::q24_t sa_c   [3];
	cdl_pkg::q24_t pw_c   [3];
	cdl_pkg::q24_t sb_c   [3];
	cdl_pkg::q24_t c_s6   [3];
	cdl_pkg::q24_t c_s7   [3];
	logic [63:0]   sp_s7  [3];
	logic          sn_s7  [3];
	cdl_pkg::q24_t c_s8   [3];
	cdl_pkg::q24_t c_s9   [3];
	cdl_pkg::q24_t ov     [4];
	logic [47:0]   m_s10  [4];
	logic          neg_s10 [4];
	logic          neg_s11 [4];
	logic          neg_s12 [4];
	logic          neg_s13 [4];
	logic          neg_s14 [4];
	logic [47:0]   low_s11 [4];
	logic [47:0]   mida_s11 [4];
	logic [39:0]   midb_s11 [4];
	logic [39:0]   high_s11 [4];
	logic [47:0]   low_s12 [4];
	logic [48:0]   mid_s12 [4];
	logic [39:0]   high_s12 [4];
	logic [63:0]   hi_s13 [4];
	logic [16:0]   t_s13  [4];
	logic [63:0]   tsum   [4];
	logic [63:0]   r_s14  [4];
	logic [31:0]   o_s15  [4];

	cdl_pkg::cdl_sat_ctrl_t sat_a_ctrl;
	cdl_pkg::cdl_sat_ctrl_t sat_b_ctrl;

	assign adv      = !vld_s[LAT-1] || !out_stall;
	assign in_stall = !adv;
	assign fwd      = !style_q[cdl_pkg::STYLE_REVERSE_BIT];
	assign rev      = style_q[cdl_pkg::STYLE_REVERSE_BIT];
	assign clamp    = !style_q[cdl_pkg::STYLE_NOCLAMP_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q     <= '0;
			slope_q     <= 48'd17592454483968;
			offset_q    <= '0;
			power_q     <= 48'd17592454483968;
			sat_q       <= 16'd4096;
			in_scale_q  <= 32'd16777216;
			out_scale_q <= 40'd16777216;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cdl_pkg::REG_STYLE:      style_q     <= cfg_data[1:0];
				cdl_pkg::REG_SLOPE:      slope_q     <= cfg_data;
				cdl_pkg::REG_OFFSET:     offset_q    <= cfg_data;
				cdl_pkg::REG_POWER:      power_q     <= cfg_data;
				cdl_pkg::REG_SATURATION: sat_q       <= cfg_data[15:0];
				cdl_pkg::REG_IN_SCALE:   in_scale_q  <= cfg_data[31:0];
				cdl_pkg::REG_OUT_SCALE:  out_scale_q <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lst_s      <= {lst_s[LAT-2:0], in_req.end_of_run};
			alpha_s[0] <= v_s2[3];
			for (int i = 1; i < MID_LAT; i++) begin
				alpha_s[i] <= alpha_s[i-1];
			end
		end
	end

	assign x_in[0] = in_req.in_red;
	assign x_in[1] = in_req.in_green;
	assign x_in[2] = in_req.in_blue;
	assign x_in[3] = in_req.in_alpha;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			ca[ch] = (rev && clamp) ? cdl_pkg::clamp01(v_s2[ch]) : v_s2[ch];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 4; ch++) begin
				isp_s1[ch] <= (x_in[ch][31] ? 32'(-x_in[ch]) : 32'(x_in[ch])) * in_scale_q;
				isn_s1[ch] <= x_in[ch][31];
				v_s2[ch]   <= cdl_pkg::mulq_fin(isp_s1[ch], isn_s1[ch], 5'd16);
			end
			for (int ch = 0; ch < 3; ch++) begin
				c_s3[ch]  <= ca[ch];
				sp_s3[ch] <= cdl_pkg::mag48(ca[ch]) * slope_q[16*ch +: 16];
				sn_s3[ch] <= ca[ch][47];
				c_s4[ch]  <= fwd ? cdl_pkg::mulq_fin(sp_s3[ch], sn_s3[ch], 5'd12) : c_s3[ch];
				c_s5[ch]  <= fwd ? cdl_pkg::add_off(c_s4[ch], offset_q[16*ch +: 16]) : c_s4[ch];
			end
		end
	end

	assign sat_a_ctrl = '{bypass: fwd, factor: sat_q};
	assign sat_b_ctrl = '{bypass: rev, factor: sat_q};

	cdl_sat_pipe u_sat_a (
		.clk   (clk),
		.adv   (adv),
		.ctrl  (sat_a_ctrl),
		.c_in  (c_s5),
		.c_out (sa_c)
	);

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_pow
			cdl_pkg::cdl_pow_ctrl_t pctrl;
			assign pctrl = '{clamp: clamp, power: power_q[16*g +: 16]};
			cdl_pow_pipe u_pow (
				.clk   (clk),
				.adv   (adv),
				.ctrl  (pctrl),
				.x_in  (sa_c[g]),
				.y_out (pw_c[g])
			);
		end
	endgenerate

	cdl_sat_pipe u_sat_b (
		.clk   (clk),
		.adv   (adv),
		.ctrl  (sat_b_ctrl),
		.c_in  (pw_c),
		.c_out (sb_c)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (fwd && clamp) begin
					c_s6[ch] <= cdl_pkg::clamp01(sb_c[ch]);
				end else if (rev) begin
					c_s6[ch] <= cdl_pkg::add_off(sb_c[ch], offset_q[16*ch +: 16]);
				end else begin
					c_s6[ch] <= sb_c[ch];
				end
				c_s7[ch]  <= c_s6[ch];
				sp_s7[ch] <= cdl_pkg::mag48(c_s6[ch]) * slope_q[16*ch +: 16];
				sn_s7[ch] <= c_s6[ch][47];
				c_s8[ch]  <= rev ? cdl_pkg::mulq_fin(sp_s7[ch], sn_s7[ch], 5'd12) : c_s7[ch];
				c_s9[ch]  <= (rev && clamp) ? cdl_pkg::clamp01(c_s8[ch]) : c_s8[ch];
			end
		end
	end

	assign ov[0] = c_s9[0];
	assign ov[1] = c_s9[1];
	assign ov[2] = c_s9[2];
	assign ov[3] = alpha_s[MID_LAT-1];

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			tsum[ch] = (64'(mid_s12[ch][7:0]) << 24) + 64'(low_s12[ch]) + 64'h8000_0000;
		end
	end

	// Output scaling in 24-bit partial products, then round and saturate to 32 bits.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 4; ch++) begin
				m_s10[ch]    <= cdl_pkg::mag48(ov[ch]);
				neg_s10[ch]  <= ov[ch][47];
				low_s11[ch]  <= m_s10[ch][23:0] * out_scale_q[23:0];
				mida_s11[ch] <= m_s10[ch][47:24] * out_scale_q[23:0];
				midb_s11[ch] <= m_s10[ch][23:0] * out_scale_q[39:24];
				high_s11[ch] <= m_s10[ch][47:24] * out_scale_q[39:24];
				neg_s11[ch]  <= neg_s10[ch];
				low_s12[ch]  <= low_s11[ch];
				mid_s12[ch]  <= 49'(mida_s11[ch]) + 49'(midb_s11[ch]);
				high_s12[ch] <= high_s11[ch];
				neg_s12[ch]  <= neg_s11[ch];
				hi_s13[ch]   <= (64'(high_s12[ch]) << 16) + 64'(mid_s12[ch] >> 8);
				t_s13[ch]    <= tsum[ch][48:32];
				neg_s13[ch]  <= neg_s12[ch];
				r_s14[ch]    <= hi_s13[ch] + 64'(t_s13[ch]);
				neg_s14[ch]  <= neg_s13[ch];
				if (neg_s14[ch]) begin
					o_s15[ch] <= (r_s14[ch] >= 64'h8000_0000) ? 32'h8000_0000 :
						32'(-r_s14[ch]);
				end else begin
					o_s15[ch] <= (r_s14[ch] > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_s14[ch][31:0];
				end
			end
		end
	end

	assign out_valid         = vld_s[LAT-1];
	assign out_req.out_red   = o_s15[0];
	assign out_req.out_green = o_s15[1];
	assign out_req.out_blue  = o_s15[2];
	assign out_req.out_alpha = o_s15[3];
	assign out_req.last_out  = lst_s[LAT-1];

`ifndef SYNTH
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_frozen_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved while stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s[0])
		else $error("accepted request not tracked");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	cdl_pkg::cdl_in_t     in_req = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b1;
	cdl_pkg::cdl_out_t    out_req;
	logic                 cfg_wr_en = 1'b0;
	logic [2:0]           cfg_index = '0;
	logic [47:0]          cfg_data = '0;

	cdl_color_grade_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the grading registers.
	logic [1:0]  g_style;
	logic [47:0] g_slope, g_offset, g_power;
	logic [15:0] g_sat;
	logic [31:0] g_in_scale;
	logic [39:0] g_out_scale;
	logic [31:0] root_q30 [1:24];

	cdl_pkg::cdl_out_t graded_q[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	bit          hold_off = 1'b0;
	bit          lazy_rx = 1'b0;

	typedef struct {
		cdl_pkg::cdl_in_t  px;
		bit                known;
		cdl_pkg::cdl_out_t res;
	} pixel_row_t;

	function automatic logic signed [63:0] clip48(input logic signed [63:0] v);
		if (v > 64'sh0000_7FFF_FFFF_FFFF) return 64'sh0000_7FFF_FFFF_FFFF;
		if (v < -64'sh0000_8000_0000_0000) return -64'sh0000_8000_0000_0000;
		return v;
	endfunction

	function automatic logic signed [63:0] rmul(input logic signed [63:0] a,
			input logic [63:0] b, input int sh);
		logic [63:0] m, r;
		m = a < 0 ? -a : a;
		r = (m * b + (64'd1 << (sh - 1))) >> sh;
		return clip48(a < 0 ? -$signed(r) : $signed(r));
	endfunction

	function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
		logic [63:0] res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] raise(input logic signed [63:0] x,
			input logic [15:0] p);
		logic [63:0] ux, m, z, acc;
		logic signed [63:0] lg, y, k, f;
		int n;
		if (p == 0) return 64'sd16777216;
		if (x <= 0) return 0;
		ux = x;
		n = 47;
		while (n > 0 && ux[n] == 1'b0) n--;
		m = n >= 31 ? ux >> (n - 31) : ux << (31 - n);
		lg = 0;
		for (int i = 0; i < 24; i++) begin
			z = m * m;
			lg = lg <<< 1;
			if (z[63]) begin
				lg |= 1;
				m = z >> 32;
			end else begin
				m = z >> 31;
			end
		end
		lg += (n - 24) * 64'sd16777216;
		y = rmul(lg, p, 12);
		if (y >= 0) k = y >>> 24;
		else k = -$signed((64'(-y) + 64'hFFFFFF) >> 24);
		if (k >= 24) return 64'sh0000_7FFF_FFFF_FFFF;
		f = y - k * 64'sd16777216;
		acc = 64'd1 << 30;
		for (int i = 1; i <= 24; i++)
			if (f[24 - i]) acc = (acc * root_q30[i] + (64'd1 << 29)) >> 30;
		if (k >= 6) begin
			acc = acc << (k - 6);
			return acc > 64'h0000_7FFF_FFFF_FFFF ? 64'sh0000_7FFF_FFFF_FFFF : $signed(acc);
		end
		if (6 - k >= 40) return 0;
		return $signed((acc + (64'd1 << (5 - k))) >> (6 - k));
	endfunction

	function automatic logic signed [63:0] unit_clip(input logic signed [63:0] v);
		return v < 0 ? 0 : (v > 64'sd16777216 ? 64'sd16777216 : v);
	endfunction

	function automatic logic [31:0] to_output(input logic signed [63:0] v);
		logic [63:0] m, mh, ml, sh, sl, lo, mid, hi, r;
		m = v < 0 ? -v : v;
		mh = m >> 24;
		ml = m & 64'hFFFFFF;
		sh = g_out_scale >> 24;
		sl = g_out_scale & 40'hFFFFFF;
		lo = ml * sl;
		mid = mh * sl + ml * sh;
		hi = mh * sh;
		r = (hi << 16) + (mid >> 8) + ((((mid & 64'hFF) << 24) + lo + (64'd1 << 31)) >> 32);
		if (v < 0) return r >= 64'h80000000 ? 32'h80000000 : 32'(-r);
		return r > 64'h7FFFFFFF ? 32'h7FFFFFFF : r[31:0];
	endfunction

	function automatic cdl_pkg::cdl_out_t grade(input cdl_pkg::cdl_in_t px);
		logic signed [63:0] c [3];
		logic signed [63:0] luma;
		logic signed [31:0] smp [3];
		bit clamp, rev;
		cdl_pkg::cdl_out_t o;
		clamp = !g_style[cdl_pkg::STYLE_NOCLAMP_BIT];
		rev = g_style[cdl_pkg::STYLE_REVERSE_BIT];
		smp[0] = px.in_red;
		smp[1] = px.in_green;
		smp[2] = px.in_blue;
		for (int i = 0; i < 3; i++) c[i] = rmul(smp[i], g_in_scale, 16);
		for (int st = 0; st < 6; st++) begin
			// Forward: slope, offset, power, saturation, clamp.
			// Reverse: clamp, saturation, power, offset, slope, clamp.
			int op;
			op = rev ? (st == 0 ? 4 : st == 1 ? 3 : st == 2 ? 2 : st == 3 ? 1 : st == 4 ? 0 : 4)
				: (st == 5 ? 5 : st == 4 ? 4 : st);
			if (op == 3) begin
				luma = clip48(rmul(c[0], 13933, 16) + rmul(c[1], 46871, 16)
					+ rmul(c[2], 4732, 16));
				for (int i = 0; i < 3; i++)
					c[i] = clip48(luma + rmul(clip48(c[i] - luma), g_sat, 12));
			end else begin
				for (int i = 0; i < 3; i++) begin
					case (op)
						0: c[i] = rmul(c[i], g_slope[16 * i +: 16], 12);
						1: c[i] = clip48(c[i] + ($signed(64'($signed(g_offset[16 * i +: 16])))
							<<< 12));
						2: begin
							if (clamp) c[i] = unit_clip(c[i]);
							if (c[i] >= 0) c[i] = raise(c[i], g_power[16 * i +: 16]);
						end
						4: if (clamp) c[i] = unit_clip(c[i]);
						default: ;
					endcase
				end
			end
		end
		o.out_red = to_output(c[0]);
		o.out_green = to_output(c[1]);
		o.out_blue = to_output(c[2]);
		o.out_alpha = to_output(rmul(px.in_alpha, g_in_scale, 16));
		o.last_out = px.end_of_run;
		return o;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			cdl_pkg::REG_STYLE: g_style = val[1:0];
			cdl_pkg::REG_SLOPE: g_slope = val;
			cdl_pkg::REG_OFFSET: g_offset = val;
			cdl_pkg::REG_POWER: g_power = val;
			cdl_pkg::REG_SATURATION: g_sat = val[15:0];
			cdl_pkg::REG_IN_SCALE: g_in_scale = val[31:0];
			cdl_pkg::REG_OUT_SCALE: g_out_scale = val[39:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (graded_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic send_pixel(input cdl_pkg::cdl_in_t px, input bit known,
			input cdl_pkg::cdl_out_t res);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_req <= px;
		in_valid <= 1'b1;
		graded_q.push_back(known ? res : grade(px));
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h10000);
			3: return -$urandom_range(0, 32'h10000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_q412(input int hi);
		return $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, hi));
	endfunction

	task automatic random_phase(input int count);
		cdl_pkg::cdl_in_t px;
		cdl_pkg::cdl_out_t none;
		none = '0;
		for (int n = 0; n < count; n++) begin
			px.in_red = rand_sample();
			px.in_green = rand_sample();
			px.in_blue = rand_sample();
			px.in_alpha = rand_sample();
			px.end_of_run = 1'($urandom);
			send_pixel(px, 1'b0, none);
		end
	endtask

	initial begin
		pixel_row_t rows [$];
		pixel_row_t row;
		logic [47:0] one3;
		logic [63:0] r;
		r = 64'd1 << 31;
		for (int i = 1; i <= 24; i++) begin
			r = sqrt_floor(r << 30);
			root_q30[i] = r[31:0];
		end
		g_style = '0;
		g_slope = 48'h1000_1000_1000;
		g_offset = '0;
		g_power = 48'h1000_1000_1000;
		g_sat = 16'h1000;
		g_in_scale = 32'h0100_0000;
		g_out_scale = 40'h00_0100_0000;
		one3 = 48'h1000_1000_1000;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Defaults give clamped identity grading.
		row.known = 1'b1;
		row.px = '{32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 1'b1};
		row.res = '{32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 1'b1};
		rows.push_back(row);
		row.px = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0};
		row.res = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0};
		rows.push_back(row);
		row.px = '{32'sh7FFFFFFF, -32'sh10000, 32'sh8000, 32'sh7FFFFFFF, 1'b0};
		row.res = '{32'sh10000, 32'sh0, 32'sh8000, 32'sh7FFFFFFF, 1'b0};
		rows.push_back(row);
		row.px = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1};
		row.res = '{32'sh0, 32'sh0, 32'sh0, 32'sh80000000, 1'b1};
		rows.push_back(row);
		row.known = 1'b0;
		row.px = '{32'sh4000, 32'sh8000, 32'shC000, 32'shFFFFFFFF, 1'b0};
		rows.push_back(row);
		row.px = '{32'sh1, 32'sh20000, -32'sh1, 32'sh1, 1'b1};
		rows.push_back(row);
		foreach (rows[i]) send_pixel(rows[i].px, rows[i].known, rows[i].res);
		drain();

		for (int ph = 0; ph < 14; ph++) begin
			write_reg(cdl_pkg::REG_STYLE, 48'(ph % 4));
			case (ph)
				0: begin
					write_reg(cdl_pkg::REG_SLOPE, '1);
					write_reg(cdl_pkg::REG_OFFSET, 48'h8000_7FFF_8000);
					write_reg(cdl_pkg::REG_POWER, '1);
					write_reg(cdl_pkg::REG_SATURATION, '1);
					write_reg(cdl_pkg::REG_IN_SCALE, '1);
					write_reg(cdl_pkg::REG_OUT_SCALE, '1);
				end
				1: begin
					write_reg(cdl_pkg::REG_SLOPE, '0);
					write_reg(cdl_pkg::REG_OFFSET, 48'h7FFF_8000_7FFF);
					write_reg(cdl_pkg::REG_POWER, '0);
					write_reg(cdl_pkg::REG_SATURATION, '0);
					write_reg(cdl_pkg::REG_IN_SCALE, '0);
					write_reg(cdl_pkg::REG_OUT_SCALE, '0);
				end
				2, 3: begin
					write_reg(cdl_pkg::REG_SLOPE, one3);
					write_reg(cdl_pkg::REG_OFFSET, '0);
					write_reg(cdl_pkg::REG_POWER, 48'h0001_0800_2000);
					write_reg(cdl_pkg::REG_SATURATION, 48'h1000);
					write_reg(cdl_pkg::REG_IN_SCALE, 48'h0100_0000);
					write_reg(cdl_pkg::REG_OUT_SCALE, 48'h0100_0000);
				end
				default: begin
					write_reg(cdl_pkg::REG_SLOPE, {rand_q412(16'h2000), rand_q412(16'h2000),
						rand_q412(16'h2000)});
					write_reg(cdl_pkg::REG_OFFSET,
						{16'($signed($urandom_range(0, 16'h1000)) - 16'sh800),
						16'($urandom), 16'($signed($urandom_range(0, 16'h1000)) - 16'sh800)});
					write_reg(cdl_pkg::REG_POWER, {rand_q412(16'h3000), rand_q412(16'h3000),
						rand_q412(16'h3000)});
					write_reg(cdl_pkg::REG_SATURATION, 48'(rand_q412(16'h2000)));
					write_reg(cdl_pkg::REG_IN_SCALE, 48'($urandom_range(0, 3) == 0 ? $urandom
						: $urandom_range(32'h0080_0000, 32'h0200_0000)));
					write_reg(cdl_pkg::REG_OUT_SCALE, 48'($urandom_range(0, 3) == 0
						? {8'($urandom), 32'($urandom)}
						: 40'($urandom_range(32'h0080_0000, 32'h0200_0000))));
				end
			endcase
			write_reg(REG_UNUSED, '1);
			lazy_rx = (ph % 3 == 1);
			if (ph == 5) hold_off = 1'b1;
			random_phase(125);
			drain();
		end
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Receiver side: random stalls, with one long hold-off while requests keep coming.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			out_stall <= 1'b0;
			@(negedge clk);
			if ($urandom_range(0, lazy_rx ? 1 : 4) == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				out_stall <= 1'b1;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cdl_pkg::cdl_out_t exp_px;
		if (arst_n && out_valid && !out_stall) begin
			if (graded_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_req);
			end else begin
				exp_px = graded_q.pop_front();
				if (out_req !== exp_px) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected r %h g %h b %h a %h l %b, got r %h g %h b %h a %h l %b",
							exp_px.out_red, exp_px.out_green, exp_px.out_blue, exp_px.out_alpha,
							exp_px.last_out, out_req.out_red, out_req.out_green, out_req.out_blue,
							out_req.out_alpha, out_req.last_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en
				|| graded_q.size() == 0) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 5000) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule

### cdl_color_grade_core.f
design/cdl_pkg.sv
design/cdl_sat_pipe.sv
design/cdl_pow_pipe.sv
design/cdl_color_grade_core.sv
bench/testbench.sv
